// ===== sv/i2cm_pkg.sv =====
// Shared types, codes and constants for the I2C register-access master.
`default_nettype none
package i2cm_pkg;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [7:0] MSB_MASK     = 8'h80;
   localparam logic [7:0] PHASE_RESET  = 8'd20;
   localparam logic [7:0] POLL_RESET   = 8'd5;
   localparam logic [2:0] LAST_BIT     = 3'd7;

   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_POLL_LIMIT  = 1'b1;

   typedef enum logic [14:0] {
      PH_IDLE     = 15'b000000000000001,
      PH_ST_HI    = 15'b000000000000010,
      PH_ST_LO    = 15'b000000000000100,
      PH_TX_LOW   = 15'b000000000001000,
      PH_TX_HIGH  = 15'b000000000010000,
      PH_ACK_LOW  = 15'b000000000100000,
      PH_ACK_HIGH = 15'b000000001000000,
      PH_RX_LOW   = 15'b000000010000000,
      PH_RX_HIGH  = 15'b000000100000000,
      PH_MA_LOW   = 15'b000001000000000,
      PH_MA_HIGH  = 15'b000010000000000,
      PH_RS_LOW   = 15'b000100000000000,
      PH_SP_LOW   = 15'b001000000000000,
      PH_SP_MID   = 15'b010000000000000,
      PH_SP_HIGH  = 15'b100000000000000
   } phase_type;

   typedef enum logic [3:0] {
      KIND_DEVW = 4'b0001,
      KIND_REG  = 4'b0010,
      KIND_DEVR = 4'b0100,
      KIND_DATA = 4'b1000
   } kind_type;

   typedef struct packed {
      logic [7:0] phase_ticks;
      logic [7:0] ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic       sda_in;
      logic [7:0] wr_data;
      logic [7:0] byte_count;
      logic [7:0] reg_addr;
      logic [6:0] dev_addr;
      logic [1:0] action;
   } item_type;

   typedef struct packed {
      logic       nack_error;
      logic       done_res;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       wr_byte_taken;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
      logic       last_byte;
   } result_type;

   typedef struct packed {
      phase_type  phase;
      kind_type   kind;
      logic [2:0] bit_index;
      logic [7:0] byte_index;
      logic [7:0] shift_byte;
      logic [7:0] phase_timer;
      logic [7:0] poll_counter;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] count;
      logic       read_mode;
      logic       abort_flag;
   } state_type;

endpackage
`default_nettype wire

// ===== sv/i2cm_core.sv =====
// Next-state and bus-level logic for one tick of the I2C master.
`default_nettype none
module i2cm_core (
   input  var i2cm_pkg::state_type  state_i,
   input  var i2cm_pkg::item_type   item_i,
   input  var i2cm_pkg::cfg_type    cfg_i,
   output i2cm_pkg::state_type      state_o,
   output i2cm_pkg::result_type     result_o
);

   i2cm_pkg::state_type  s;
   i2cm_pkg::result_type r;
   logic [7:0] pt;
   logic [7:0] lim;
   logic       last_rx;
   logic [7:0] poll_next;

   always_comb begin
      s = state_i;
      r = '0;
      r.scl_out = 1'b1;
      r.sda_out = 1'b1;
      pt  = (cfg_i.phase_ticks == 8'd0) ? 8'd1 : cfg_i.phase_ticks;
      lim = (cfg_i.ack_poll_limit == 8'd0) ? 8'd1 : cfg_i.ack_poll_limit;
      poll_next = 8'd0;

      // A command is taken only on the idle bus; its tick is the first START tick.
      if (s.phase == i2cm_pkg::PH_IDLE &&
          (item_i.action == i2cm_pkg::ACT_WRITE || item_i.action == i2cm_pkg::ACT_READ)) begin
         s.dev_addr     = item_i.dev_addr;
         s.reg_addr     = item_i.reg_addr;
         s.count        = item_i.byte_count;
         s.read_mode    = (item_i.action == i2cm_pkg::ACT_READ);
         s.shift_byte   = {item_i.dev_addr, 1'b0};
         s.kind         = i2cm_pkg::KIND_DEVW;
         s.bit_index    = 3'd0;
         s.byte_index   = 8'd0;
         s.poll_counter = 8'd0;
         s.abort_flag   = 1'b0;
         s.phase        = i2cm_pkg::PH_ST_HI;
         s.phase_timer  = 8'd0;
      end

      last_rx = ({1'b0, s.byte_index} + 9'd1) == {1'b0, s.count};

      unique case (s.phase)
         i2cm_pkg::PH_ST_LO: r.sda_out = 1'b0;
         i2cm_pkg::PH_TX_LOW: begin
            r.scl_out = 1'b0;
            r.sda_out = |(s.shift_byte & i2cm_pkg::MSB_MASK);
         end
         i2cm_pkg::PH_TX_HIGH: r.sda_out = |(s.shift_byte & i2cm_pkg::MSB_MASK);
         i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_RX_LOW, i2cm_pkg::PH_RS_LOW: r.scl_out = 1'b0;
         i2cm_pkg::PH_MA_LOW: begin
            r.scl_out = 1'b0;
            r.sda_out = last_rx;
         end
         i2cm_pkg::PH_MA_HIGH: r.sda_out = last_rx;
         i2cm_pkg::PH_SP_LOW: begin
            r.scl_out = 1'b0;
            r.sda_out = 1'b0;
         end
         i2cm_pkg::PH_SP_MID: r.sda_out = 1'b0;
         default: ;
      endcase

      if (s.phase != i2cm_pkg::PH_IDLE) begin
         if (({1'b0, s.phase_timer} + 9'd1) < {1'b0, pt}) begin
            s.phase_timer = s.phase_timer + 8'd1;
         end else begin
            s.phase_timer = 8'd0;
            unique case (s.phase)
               i2cm_pkg::PH_ST_HI: s.phase = i2cm_pkg::PH_ST_LO;
               i2cm_pkg::PH_ST_LO: begin
                  s.bit_index = 3'd0;
                  s.phase     = i2cm_pkg::PH_TX_LOW;
               end
               i2cm_pkg::PH_TX_LOW: s.phase = i2cm_pkg::PH_TX_HIGH;
               i2cm_pkg::PH_TX_HIGH: begin
                  if (s.bit_index == i2cm_pkg::LAST_BIT) begin
                     s.poll_counter = 8'd0;
                     s.phase        = i2cm_pkg::PH_ACK_LOW;
                  end else begin
                     s.bit_index  = s.bit_index + 3'd1;
                     s.shift_byte = {s.shift_byte[6:0], 1'b0};
                     s.phase      = i2cm_pkg::PH_TX_LOW;
                  end
               end
               i2cm_pkg::PH_ACK_LOW: s.phase = i2cm_pkg::PH_ACK_HIGH;
               i2cm_pkg::PH_ACK_HIGH: begin
                  if (!item_i.sda_in) begin
                     unique case (s.kind)
                        i2cm_pkg::KIND_DEVW: begin
                           s.shift_byte = s.reg_addr;
                           s.kind       = i2cm_pkg::KIND_REG;
                           s.bit_index  = 3'd0;
                           s.phase      = i2cm_pkg::PH_TX_LOW;
                        end
                        i2cm_pkg::KIND_REG: begin
                           if (s.read_mode) begin
                              s.phase = i2cm_pkg::PH_RS_LOW;
                           end else if (s.count == 8'd0) begin
                              s.phase = i2cm_pkg::PH_SP_LOW;
                           end else begin
                              s.byte_index    = 8'd0;
                              s.shift_byte    = item_i.wr_data;
                              s.kind          = i2cm_pkg::KIND_DATA;
                              s.bit_index     = 3'd0;
                              r.wr_byte_taken = 1'b1;
                              r.last_byte     = (s.count == 8'd1);
                              s.phase         = i2cm_pkg::PH_TX_LOW;
                           end
                        end
                        i2cm_pkg::KIND_DEVR: begin
                           if (s.count == 8'd0) begin
                              s.phase = i2cm_pkg::PH_SP_LOW;
                           end else begin
                              s.byte_index = 8'd0;
                              s.bit_index  = 3'd0;
                              s.shift_byte = 8'd0;
                              s.phase      = i2cm_pkg::PH_RX_LOW;
                           end
                        end
                        default: begin
                           s.byte_index = s.byte_index + 8'd1;
                           if (s.byte_index == s.count) begin
                              s.phase = i2cm_pkg::PH_SP_LOW;
                           end else begin
                              s.shift_byte    = item_i.wr_data;
                              s.kind          = i2cm_pkg::KIND_DATA;
                              s.bit_index     = 3'd0;
                              r.wr_byte_taken = 1'b1;
                              r.last_byte     = ({1'b0, s.byte_index} + 9'd1)
                                                == {1'b0, s.count};
                              s.phase         = i2cm_pkg::PH_TX_LOW;
                           end
                        end
                     endcase
                  end else begin
                     poll_next      = s.poll_counter + 8'd1;
                     s.poll_counter = poll_next;
                     if (poll_next >= lim) begin
                        s.abort_flag = 1'b1;
                        s.phase      = i2cm_pkg::PH_SP_LOW;
                     end
                  end
               end
               i2cm_pkg::PH_RS_LOW: begin
                  s.shift_byte = {s.dev_addr, 1'b1};
                  s.kind       = i2cm_pkg::KIND_DEVR;
                  s.phase      = i2cm_pkg::PH_ST_HI;
               end
               i2cm_pkg::PH_RX_LOW: s.phase = i2cm_pkg::PH_RX_HIGH;
               i2cm_pkg::PH_RX_HIGH: begin
                  s.shift_byte = {s.shift_byte[6:0], item_i.sda_in};
                  if (s.bit_index == i2cm_pkg::LAST_BIT) begin
                     r.rd_valid  = 1'b1;
                     r.rd_data   = s.shift_byte;
                     r.last_byte = last_rx;
                     s.phase     = i2cm_pkg::PH_MA_LOW;
                  end else begin
                     s.bit_index = s.bit_index + 3'd1;
                     s.phase     = i2cm_pkg::PH_RX_LOW;
                  end
               end
               i2cm_pkg::PH_MA_LOW: s.phase = i2cm_pkg::PH_MA_HIGH;
               i2cm_pkg::PH_MA_HIGH: begin
                  if (last_rx) begin
                     s.phase = i2cm_pkg::PH_SP_LOW;
                  end else begin
                     s.byte_index = s.byte_index + 8'd1;
                     s.bit_index  = 3'd0;
                     s.shift_byte = 8'd0;
                     s.phase      = i2cm_pkg::PH_RX_LOW;
                  end
               end
               i2cm_pkg::PH_SP_LOW: s.phase = i2cm_pkg::PH_SP_MID;
               i2cm_pkg::PH_SP_MID: s.phase = i2cm_pkg::PH_SP_HIGH;
               default: begin
                  r.done_res   = 1'b1;
                  r.nack_error = s.abort_flag;
                  s.abort_flag = 1'b0;
                  s.phase      = i2cm_pkg::PH_IDLE;
               end
            endcase
         end
      end

      r.busy_res = (s.phase != i2cm_pkg::PH_IDLE);
   end

   assign state_o  = s;
   assign result_o = r;

endmodule
`default_nettype wire

// ===== sv/i2c_master_register_access.sv =====
// Top level of the I2C register-access master: request, result and register stages.
//
//   channel | direction | payload                                   | handshake
//   req_    | in        | tuser: action; tdata: dev_addr, reg_addr, | tvalid/tready
//           |           |   byte_count, wr_data, sda_in             |
//   rsp_    | out       | tdata: bus levels, handshakes, status;    | tvalid/tready
//           |           |   tlast: last_byte                        |
//   csr_    | in        | index, data (phase_ticks, ack_poll_limit) | valid/ready
//
// One request (one tick) is taken every cycle unless a stalled result holds the request
// register full. A taken request sits in the request register while the core works on
// it, and its result enters the result register once that register is free or emptied.
// The bus sequencer state is updated once per request in a single pass through the core.
// Reset is synchronous and restores the idle bus and the register defaults.
// A stalled result holds the result register; the request register then holds too,
// and req_tready drops only while both are full and the result is stalled.
`default_nettype none
module i2c_master_register_access (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [1:0] action
   input  wire  [1:0]  req_tuser,
   // [6:0] dev_addr, [14:7] reg_addr, [22:15] byte_count, [30:23] wr_data, [31] sda_in
   input  wire  [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] wr_byte_taken, [4] rd_valid,
   // [12:5] rd_data, [13] done_res, [14] nack_error, [15] zero
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [7:0]  csr_data
);

   i2cm_pkg::cfg_type    cfg_ff, cfg_in;
   i2cm_pkg::state_type  state_ff, state_in;
   i2cm_pkg::item_type   item_ff, item_in;
   i2cm_pkg::result_type result_ff, result_in;
   i2cm_pkg::state_type  core_state;
   i2cm_pkg::result_type core_result;
   logic                 item_vld_ff, item_vld_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 advance;

   i2cm_core u_core (
      .state_i  (state_ff),
      .item_i   (item_ff),
      .cfg_i    (cfg_ff),
      .state_o  (core_state),
      .result_o (core_result)
   );

   assign advance    = item_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !item_vld_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            i2cm_pkg::CSR_PHASE_TICKS: cfg_in.phase_ticks    = csr_data;
            i2cm_pkg::CSR_POLL_LIMIT:  cfg_in.ack_poll_limit = csr_data;
            default: ;
         endcase
      end

      item_in     = item_ff;
      item_vld_in = item_vld_ff;
      if (req_tready) begin
         item_vld_in = req_tvalid;
         item_in     = {req_tdata, req_tuser};
      end

      state_in  = advance ? core_state : state_ff;
      result_in = advance ? core_result : result_ff;
      rsp_vld_in = advance ? 1'b1 : (rsp_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks      <= i2cm_pkg::PHASE_RESET;
         cfg_ff.ack_poll_limit   <= i2cm_pkg::POLL_RESET;
         state_ff.phase          <= i2cm_pkg::PH_IDLE;
         state_ff.kind           <= i2cm_pkg::KIND_DEVW;
         state_ff.bit_index      <= 3'd0;
         state_ff.byte_index     <= 8'd0;
         state_ff.shift_byte     <= 8'd0;
         state_ff.phase_timer    <= 8'd0;
         state_ff.poll_counter   <= 8'd0;
         state_ff.dev_addr       <= 7'd0;
         state_ff.reg_addr       <= 8'd0;
         state_ff.count          <= 8'd0;
         state_ff.read_mode      <= 1'b0;
         state_ff.abort_flag     <= 1'b0;
         item_vld_ff             <= 1'b0;
         rsp_vld_ff              <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         state_ff    <= state_in;
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, result_ff.nack_error, result_ff.done_res, result_ff.rd_data,
                        result_ff.rd_valid, result_ff.wr_byte_taken, result_ff.busy_res,
                        result_ff.sda_out, result_ff.scl_out};
   assign rsp_tlast  = result_ff.last_byte;

endmodule
`default_nettype wire

// ===== sv/i2cm_checker.sv =====
// Port-level checks for the I2C register-access master, bound to the top level.
`default_nettype none
module i2cm_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata,
   input wire        rsp_tlast
);

   // A stalled result must hold still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // The error flag only comes with the end of a transaction.
   a_nack_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14] |-> rsp_tdata[13])
      else $error("nack_error without done_res");

   // The read byte reads as zero unless a byte was delivered.
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[12:5] == 8'd0)
      else $error("rd_data set without rd_valid");

   // The stop finishes with both lines released and the block idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> !rsp_tdata[2] && rsp_tdata[0] && rsp_tdata[1]
                                      && !rsp_tlast)
      else $error("done_res while bus not released");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== bench/i2c_transfer_checker.sv =====
// Checker for the I2C register-access master: predicts every result and compares it.
module i2c_transfer_checker
   import i2cm_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire [1:0]  req_tuser,
   input  wire [31:0] req_tdata,
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire [15:0] rsp_tdata,
   input  wire        rsp_tlast,
   input  wire        csr_valid,
   input  wire        csr_ready,
   input  wire        csr_index,
   input  wire [7:0]  csr_data,
   input  wire        drain_check,
   output int         fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Own copy of the bus sequencer and its settings.
   phase_type  phase;
   kind_type   kind;
   logic [2:0] bit_pos;
   logic [7:0] byte_pos;
   logic [7:0] shifter;
   logic [7:0] timer;
   logic [7:0] polls;
   logic [6:0] dev;
   logic [7:0] regad;
   logic [7:0] count;
   logic       is_read;
   logic       aborting;
   cfg_type    cfg;

   result_type tick_results_due[$];
   result_type want;
   logic       drained;

   function automatic void enter(input phase_type next);
      phase = next;
      timer = '0;
   endfunction

   // Loads the next write byte and tells whether it closes the burst.
   function automatic logic load_data_byte(input logic [7:0] data);
      shifter = data;
      kind    = KIND_DATA;
      bit_pos = '0;
      enter(PH_TX_LOW);
      return ({1'b0, byte_pos} + 9'd1 == {1'b0, count});
   endfunction

   function automatic result_type sequence_tick(input item_type it);
      logic [7:0] span;
      logic [7:0] limit;
      logic       last_rx;
      result_type r;
      span  = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
      limit = (cfg.ack_poll_limit == 8'd0) ? 8'd1 : cfg.ack_poll_limit;
      r = '0;
      r.scl_out = 1'b1;
      r.sda_out = 1'b1;

      if (phase == PH_IDLE && (it.action == ACT_WRITE || it.action == ACT_READ)) begin
         dev      = it.dev_addr;
         regad    = it.reg_addr;
         count    = it.byte_count;
         is_read  = (it.action == ACT_READ);
         shifter  = {it.dev_addr, 1'b0};
         kind     = KIND_DEVW;
         bit_pos  = '0;
         byte_pos = '0;
         polls    = '0;
         aborting = 1'b0;
         enter(PH_ST_HI);
      end

      last_rx = ({1'b0, byte_pos} + 9'd1 == {1'b0, count});

      case (phase)
         PH_ST_LO: r.sda_out = 1'b0;
         PH_TX_LOW: begin
            r.scl_out = 1'b0;
            r.sda_out = |(shifter & MSB_MASK);
         end
         PH_TX_HIGH: r.sda_out = |(shifter & MSB_MASK);
         PH_ACK_LOW, PH_RX_LOW, PH_RS_LOW: r.scl_out = 1'b0;
         PH_MA_LOW: begin
            r.scl_out = 1'b0;
            r.sda_out = last_rx;
         end
         PH_MA_HIGH: r.sda_out = last_rx;
         PH_SP_LOW: begin
            r.scl_out = 1'b0;
            r.sda_out = 1'b0;
         end
         PH_SP_MID: r.sda_out = 1'b0;
         default: ;
      endcase

      if (phase != PH_IDLE) begin
         if ({1'b0, timer} + 9'd1 < {1'b0, span}) begin
            timer = timer + 8'd1;
         end else begin
            timer = '0;
            case (phase)
               PH_ST_HI: enter(PH_ST_LO);
               PH_ST_LO: begin
                  bit_pos = '0;
                  enter(PH_TX_LOW);
               end
               PH_TX_LOW: enter(PH_TX_HIGH);
               PH_TX_HIGH: begin
                  if (bit_pos == LAST_BIT) begin
                     polls = '0;
                     enter(PH_ACK_LOW);
                  end else begin
                     bit_pos = bit_pos + 3'd1;
                     shifter = {shifter[6:0], 1'b0};
                     enter(PH_TX_LOW);
                  end
               end
               PH_ACK_LOW: enter(PH_ACK_HIGH);
               PH_ACK_HIGH: begin
                  if (!it.sda_in) begin
                     case (kind)
                        KIND_DEVW: begin
                           shifter = regad;
                           kind    = KIND_REG;
                           bit_pos = '0;
                           enter(PH_TX_LOW);
                        end
                        KIND_REG: begin
                           if (is_read) begin
                              enter(PH_RS_LOW);
                           end else if (count == 8'd0) begin
                              enter(PH_SP_LOW);
                           end else begin
                              byte_pos = '0;
                              r.wr_byte_taken = 1'b1;
                              r.last_byte = load_data_byte(it.wr_data);
                           end
                        end
                        KIND_DEVR: begin
                           if (count == 8'd0) begin
                              enter(PH_SP_LOW);
                           end else begin
                              byte_pos = '0;
                              bit_pos  = '0;
                              shifter  = '0;
                              enter(PH_RX_LOW);
                           end
                        end
                        default: begin
                           byte_pos = byte_pos + 8'd1;
                           if (byte_pos == count) begin
                              enter(PH_SP_LOW);
                           end else begin
                              r.wr_byte_taken = 1'b1;
                              r.last_byte = load_data_byte(it.wr_data);
                           end
                        end
                     endcase
                  end else begin
                     // No acknowledge yet: the phase repeats until the poll budget is spent.
                     polls = polls + 8'd1;
                     if (polls >= limit) begin
                        aborting = 1'b1;
                        enter(PH_SP_LOW);
                     end
                  end
               end
               PH_RS_LOW: begin
                  shifter = {dev, 1'b1};
                  kind    = KIND_DEVR;
                  enter(PH_ST_HI);
               end
               PH_RX_LOW: enter(PH_RX_HIGH);
               PH_RX_HIGH: begin
                  shifter = {shifter[6:0], it.sda_in};
                  if (bit_pos == LAST_BIT) begin
                     r.rd_valid  = 1'b1;
                     r.rd_data   = shifter;
                     r.last_byte = last_rx;
                     enter(PH_MA_LOW);
                  end else begin
                     bit_pos = bit_pos + 3'd1;
                     enter(PH_RX_LOW);
                  end
               end
               PH_MA_LOW: enter(PH_MA_HIGH);
               PH_MA_HIGH: begin
                  if (last_rx) begin
                     enter(PH_SP_LOW);
                  end else begin
                     byte_pos = byte_pos + 8'd1;
                     bit_pos  = '0;
                     shifter  = '0;
                     enter(PH_RX_LOW);
                  end
               end
               PH_SP_LOW: enter(PH_SP_MID);
               PH_SP_MID: enter(PH_SP_HIGH);
               PH_SP_HIGH: begin
                  r.done_res   = 1'b1;
                  r.nack_error = aborting;
                  aborting     = 1'b0;
                  enter(PH_IDLE);
               end
               default: ;
            endcase
         end
      end

      r.busy_res = (phase != PH_IDLE);
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned expected_value,
                                       input int unsigned actual_value);
      if (expected_value != actual_value) begin
         $error("%s: expected %0h, actual %0h", name, expected_value, actual_value);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase    = PH_IDLE;
         kind     = KIND_DEVW;
         bit_pos  = '0;
         byte_pos = '0;
         shifter  = '0;
         timer    = '0;
         polls    = '0;
         dev      = '0;
         regad    = '0;
         count    = '0;
         is_read  = 1'b0;
         aborting = 1'b0;
         cfg.phase_ticks    = PHASE_RESET;
         cfg.ack_poll_limit = POLL_RESET;
         tick_results_due.delete();
         fail_count = 0;
         drained    = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tick_results_due.size() == 0) begin
               $error("result %h arrived with no request outstanding", rsp_tdata);
               fail_count++;
            end else begin
               want = tick_results_due.pop_front();
               check_field("scl_out", want.scl_out, rsp_tdata[0]);
               check_field("sda_out", want.sda_out, rsp_tdata[1]);
               check_field("busy_res", want.busy_res, rsp_tdata[2]);
               check_field("wr_byte_taken", want.wr_byte_taken, rsp_tdata[3]);
               check_field("rd_valid", want.rd_valid, rsp_tdata[4]);
               check_field("rd_data", want.rd_data, rsp_tdata[12:5]);
               check_field("done_res", want.done_res, rsp_tdata[13]);
               check_field("nack_error", want.nack_error, rsp_tdata[14]);
               check_field("last_byte", want.last_byte, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            tick_results_due.push_back(sequence_tick(item_type'({req_tdata, req_tuser})));
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PHASE_TICKS) begin
               cfg.phase_ticks = csr_data;
            end else begin
               cfg.ack_poll_limit = csr_data;
            end
         end
         if (drain_check && !drained) begin
            if (tick_results_due.size() != 0) begin
               $error("%0d results never arrived", tick_results_due.size());
               fail_count += tick_results_due.size();
            end
            drained = 1'b1;
         end
      end
   end

endmodule

// ===== bench/i2c_master_register_access_test.sv =====
// Testbench top for the I2C register-access master: request stimulus, settings and verdict.
module i2c_master_register_access_test;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cm_pkg::*;

   // Several times the slowest expected run, stalls included.
   localparam int unsigned CYCLE_LIMIT = 50_000;
   localparam int RSP_BUSY = 2;
   localparam int RSP_DONE = 13;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [1:0]  req_tuser   = '0;
   logic [31:0] req_tdata   = '0;
   logic        rsp_tready  = 1'b0;
   logic        csr_valid   = 1'b0;
   logic        csr_index   = CSR_PHASE_TICKS;
   logic [7:0]  csr_data    = '0;
   logic        drain_check = 1'b0;

   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;
   wire         rsp_tlast;
   wire         csr_ready;
   int          fail_count;

   int unsigned cycle_count    = 0;
   int unsigned results_seen   = 0;
   int unsigned transfers_done = 0;
   int unsigned requests_sent  = 0;
   int unsigned done_mark      = 0;
   logic        last_busy      = 1'b0;
   int unsigned send_gap_pct   = 0;
   int unsigned stall_pct      = 0;
   int unsigned ack_pct        = 100;

   i2c_master_register_access dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   i2c_transfer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .drain_check (drain_check),
      .fail_count  (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Result tracking for the stimulus side, plus the run ceiling.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         last_busy    <= rsp_tdata[RSP_BUSY];
         if (rsp_tdata[RSP_DONE]) begin
            transfers_done <= transfers_done + 1;
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("i2c_master_register_access_test: FAIL");
         $finish;
      end
   end

   task automatic set_idle(input int mode);
      case (mode)
         0: begin
            send_gap_pct = 0;
            stall_pct   <= 0;
         end
         1: begin
            send_gap_pct = 59;
            stall_pct   <= 0;
         end
         2: begin
            send_gap_pct = 0;
            stall_pct   <= 59;
         end
         default: begin
            send_gap_pct = 37;
            stall_pct   <= 37;
         end
      endcase
   endtask

   function automatic item_type tick_item(input logic [1:0] act);
      item_type it;
      it.action     = act;
      it.dev_addr   = 7'($urandom_range(0, 127));
      it.reg_addr   = 8'($urandom_range(0, 255));
      it.byte_count = 8'($urandom_range(0, 255));
      it.wr_data    = 8'($urandom_range(0, 255));
      it.sda_in     = ($urandom_range(0, 99) >= ack_pct);
      return it;
   endfunction

   task automatic push_request(input item_type it);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      {req_tdata, req_tuser} <= it;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic push_ticks(input int unsigned n);
      repeat (n) push_request(tick_item(ACT_TICK));
   endtask

   task automatic drain_results();
      while (results_seen != requests_sent) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic apply_setting(input logic [7:0] span, input logic [7:0] limit);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_PHASE_TICKS;
      csr_data  <= span;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_POLL_LIMIT;
      csr_data  <= limit;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One command request on the idle bus.
   task automatic begin_transfer(input logic [1:0] act, input logic [6:0] dev,
                                 input logic [7:0] regad, input logic [7:0] count,
                                 input int unsigned ack);
      item_type it;
      ack_pct   = ack;
      done_mark = transfers_done;
      it = tick_item(act);
      it.dev_addr   = dev;
      it.reg_addr   = regad;
      it.byte_count = count;
      push_request(it);
   endtask

   // Ticks until the block reports the stop condition.
   task automatic tick_until_done();
      item_type it;
      while (transfers_done == done_mark) begin
         if ($urandom_range(0, 49) == 0) begin
            // A command is ignored only while the bus is busy, so it goes out once every
            // earlier request has come back and the latest one still showed the bus busy.
            drain_results();
            it = tick_item(last_busy ? ($urandom_range(0, 1) ? ACT_WRITE : ACT_READ)
                                     : ACT_TICK);
         end else begin
            it = tick_item(($urandom_range(0, 31) == 0) ? (ACT_WRITE | ACT_READ) : ACT_TICK);
         end
         push_request(it);
      end
   endtask

   task automatic run_transfer(input logic [1:0] act, input logic [6:0] dev,
                               input logic [7:0] regad, input logic [7:0] count,
                               input int unsigned ack);
      begin_transfer(act, dev, regad, count, ack);
      tick_until_done();
   endtask

   task automatic random_transfer();
      int unsigned ack;
      ack = $urandom_range(0, 1) ? 95 : 60;
      run_transfer($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, 7'($urandom_range(0, 127)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 2)), ack);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The reset timing drives the start condition; the bus is then sped up mid-transfer.
      set_idle(0);
      begin_transfer(ACT_WRITE, 7'h00, 8'h00, 8'd0, 100);
      push_ticks(50);
      apply_setting(8'd1, 8'd1);
      tick_until_done();
      run_transfer(ACT_READ, 7'h7F, 8'hFF, 8'd1, 100);

      set_idle(1);
      run_transfer(ACT_WRITE, 7'h55, 8'hAA, 8'd2, 100);
      run_transfer(ACT_WRITE, 7'h12, 8'h34, 8'd1, 0);

      apply_setting(8'd0, 8'd0);
      set_idle(2);
      run_transfer(ACT_READ, 7'h2A, 8'h55, 8'd0, 100);
      run_transfer(ACT_READ, 7'h21, 8'h43, 8'd2, 60);

      apply_setting(8'd2, 8'd3);
      set_idle(3);
      run_transfer(ACT_WRITE, 7'h33, 8'h0F, 8'd1, 0);
      apply_setting(8'd1, 8'hFF);
      run_transfer(ACT_WRITE, 7'h40, 8'h01, 8'd1, 60);
      random_transfer();

      drain_results();
      repeat (8) @(posedge clock);
      drain_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("i2c_master_register_access_test: PASS");
      end else begin
         $display("i2c_master_register_access_test: FAIL");
      end
      $finish;
   end

endmodule
